### src/plq_pkg.sv
`timescale 1ns / 1ps
// Package for the min-level priority queue: operation and status codes,
// default sizes and the result record shared by the sequencer and the top level.
package plq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_LEVEL_BITS = 8;

    localparam int VALUE_W     = 32;
    localparam int IN_LEVEL_W  = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

endpackage

### src/plq_mem.sv
`timescale 1ns / 1ps
// Entry storage for the priority queue: one write port and one registered read port.
// Depends on nothing outside this file.
module plq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/plq_seq.sv
`timescale 1ns / 1ps
// Sequencer of the priority queue: one level comparator scans the entries, then the
// entries above a removed one move down one slot a cycle. Depends on plq_pkg and plq_mem.
module plq_seq #(
    parameter int CAPACITY   = plq_pkg::DEF_CAPACITY,
    parameter int LEVEL_BITS = plq_pkg::DEF_LEVEL_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [1:0]                    mode,
    input  logic [plq_pkg::VALUE_W-1:0]   value,
    input  logic [LEVEL_BITS-1:0]         level,
    input  logic                          out_free,
    output logic                          ready,
    output logic                          done,
    output plq_pkg::result_t              result
);
    import plq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = VALUE_W + LEVEL_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         wr_idx_reg, wr_idx_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [LEVEL_BITS-1:0] best_lvl_reg, best_lvl_next;
    logic [VALUE_W-1:0]    best_val_reg, best_val_next;
    logic                  is_deq_reg, is_deq_next;
    logic [VALUE_W-1:0]    res_val_reg, res_val_next;
    logic [1:0]            stat_reg, stat_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [EW-1:0]         mem_rdata;

    logic [LEVEL_BITS-1:0] rd_lvl;
    logic [VALUE_W-1:0]    rd_val;
    logic                  take;
    logic [AW-1:0]         cur_idx;
    logic [VALUE_W-1:0]    cur_val;
    logic [CW-1:0]         last_idx;
    logic [CW-1:0]         cur_idx_plus1;
    logic [CW-1:0]         wr_idx_plus2;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    plq_mem #(
        .DEPTH(CAPACITY),
        .WIDTH(EW)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    assign rd_val        = mem_rdata[VALUE_W-1:0];
    assign rd_lvl        = mem_rdata[EW-1:VALUE_W];
    assign take          = (rd_idx_reg == '0) || (rd_lvl < best_lvl_reg);
    assign cur_idx       = take ? rd_idx_reg : best_idx_reg;
    assign cur_val       = take ? rd_val : best_val_reg;
    assign last_idx      = count_reg - CW'(1);
    assign cur_idx_plus1 = CW'(cur_idx) + CW'(1);
    assign wr_idx_plus2  = CW'(wr_idx_reg) + CW'(2);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        best_idx_next = best_idx_reg;
        best_lvl_next = best_lvl_reg;
        best_val_next = best_val_reg;
        is_deq_next   = is_deq_reg;
        res_val_next  = res_val_reg;
        stat_next     = stat_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_idx_reg;
        mem_wdata     = mem_rdata;
        mem_raddr     = rd_idx_reg + AW'(1);
        done          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                mem_raddr = '0;
                if (start) begin
                    res_val_next = '0;
                    stat_next    = STAT_OK;
                    state_next   = S_FIN;
                    case (mode)
                        MODE_ENQ: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                stat_next = STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {level, value};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_DEQ, MODE_PEEK: begin
                            if (count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                is_deq_next = (mode == MODE_DEQ);
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default: begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                best_idx_next = cur_idx;
                best_lvl_next = take ? rd_lvl : best_lvl_reg;
                best_val_next = cur_val;
                rd_idx_next   = rd_idx_reg + AW'(1);
                if (CW'(rd_idx_reg) == last_idx) begin
                    res_val_next = cur_val;
                    state_next   = S_FIN;
                    if (is_deq_reg) begin
                        if (CW'(cur_idx) == last_idx) begin
                            count_next = count_reg - CW'(1);
                        end else begin
                            mem_raddr   = cur_idx_plus1[AW-1:0];
                            wr_idx_next = cur_idx;
                            state_next  = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                mem_we = 1'b1;
                if (wr_idx_plus2 == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end else begin
                    mem_raddr   = wr_idx_plus2[AW-1:0];
                    wr_idx_next = wr_idx_reg + AW'(1);
                end
            end
            S_FIN: begin
                done = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        best_idx_reg <= best_idx_next;
        best_lvl_reg <= best_lvl_next;
        best_val_reg <= best_val_next;
        is_deq_reg   <= is_deq_next;
        res_val_reg  <= res_val_next;
        stat_reg     <= stat_next;
    end

    assign count_wide    = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign ready         = (state_reg == S_IDLE);
    assign result.value  = res_val_reg;
    assign result.status = stat_reg;
    assign result.count  = count_wide[COUNT_OUT_W-1:0];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> CW'(rd_idx_reg) < count_reg)
        else $error("Scan index runs past the held entries.");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> CW'(wr_idx_reg) + CW'(1) < count_reg)
        else $error("Shift reads past the held entries.");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && stat_reg == STAT_EMPTY) |-> count_reg == '0)
        else $error("Empty status reported while entries are held.");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && stat_reg == STAT_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("Full status reported while space remains.");

endmodule

### src/min_level_priority_queue.sv
`timescale 1ns / 1ps
// Bounded min-level priority queue of CAPACITY entries held in arrival order.
// Accepts one operation beat on the s_ channel and returns one result beat on m_.
// Operations (s_tuser): enqueue, dequeue minimum, peek minimum. The smallest level
// wins and a tie goes to the oldest entry; a dequeue returns the removed value.
// An enqueue, a rejected operation or an empty queue goes straight from idle to
// the finish state. A peek or dequeue scans every held entry with the one level
// comparator, which visits one memory entry a cycle through the single read port;
// a dequeue then also moves each younger entry down one slot behind the removed one.
// One operation is in flight at a time; s_tready is high only while idle, so a
// new operation is not taken until the sequencer is idle again. A finished
// result sits in the output register, so the next operation may be taken while
// the receiver stalls; the sequencer then holds its result until the output
// register is free.
// Synchronous active-low reset empties the queue; stored entries keep no reset value.
// Depends on plq_pkg, plq_seq and plq_mem.
module min_level_priority_queue #(
    parameter int CAPACITY   = plq_pkg::DEF_CAPACITY,
    parameter int LEVEL_BITS = plq_pkg::DEF_LEVEL_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value [31:0], item_level [39:32]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value [31:0], entry_count [36:32], zero [39:37]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import plq_pkg::*;

    logic                          accept;
    logic                          out_free;
    logic                          seq_ready;
    logic                          seq_done;
    result_t                       seq_result;
    logic [IN_LEVEL_W+LEVEL_BITS-1:0] level_wide;

    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = seq_ready;
    assign out_free   = !m_valid_reg || m_tready;
    assign level_wide = {{LEVEL_BITS{1'b0}}, s_tdata[VALUE_W+IN_LEVEL_W-1:VALUE_W]};

    plq_seq #(
        .CAPACITY  (CAPACITY),
        .LEVEL_BITS(LEVEL_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mode    (s_tuser),
        .value   (s_tdata[VALUE_W-1:0]),
        .level   (level_wide[LEVEL_BITS-1:0]),
        .out_free(out_free),
        .ready   (seq_ready),
        .done    (seq_done),
        .result  (seq_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (seq_done) begin
            m_valid_next = 1'b1;
            out_next     = seq_result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.value};
    assign m_tuser  = out_reg.status;

endmodule
